FILE: src/decreasing_triple_counter_unit_macros.svh
// ----------------------------------------------------------------------------
// decreasing triple counter assertion macros
// shared concurrent check forms, clocked and held off while in reset
// ----------------------------------------------------------------------------
`ifndef DECREASING_TRIPLE_COUNTER_UNIT_MACROS_SVH
`define DECREASING_TRIPLE_COUNTER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// shared constants and control types of the decreasing triple counter
// ----------------------------------------------------------------------------
package dtc_pkg;

    // default sizing
    localparam int DTC_MAX_ITEMS  = 1024;
    localparam int DTC_VALUE_BITS = 32;

    // fixed field widths of the channels
    localparam int DTC_IN_VALUE_W = 32;
    localparam int DTC_TOTAL_W    = 28;

    // control bits that travel with an item along the chain
    typedef struct packed {
        logic valid;
        logic last;
        logic dropped;
    } t_ctl;

endpackage

FILE: src/dtc_if.sv
// ----------------------------------------------------------------------------
// dtc channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface dtc_in_if;
    logic                              valid;
    logic                              ready;
    logic [dtc_pkg::DTC_IN_VALUE_W-1:0] value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface dtc_out_if;
    logic                           valid;
    logic                           ready;
    logic [dtc_pkg::DTC_TOTAL_W-1:0] triple_total;
    logic                           overflowed;
    logic                           is_final;

    modport source (output valid, output triple_total, output overflowed,
                    output is_final, input ready);
    modport sink   (input valid, input triple_total, input overflowed,
                    input is_final, output ready);
endinterface

FILE: src/dtc_cell.sv
// ----------------------------------------------------------------------------
// dtc_cell
// one slot of the store: holds a kept value and its earlier-greater count,
// updates the passing item and hands it to the next cell
// ----------------------------------------------------------------------------
module dtc_cell #(
    parameter int INDEX      = 0,
    parameter int MAX_ITEMS  = dtc_pkg::DTC_MAX_ITEMS,
    parameter int VALUE_BITS = dtc_pkg::DTC_VALUE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  dtc_pkg::t_ctl                         i_ctl,
    input  logic [VALUE_BITS-1:0]                 i_val,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]        i_slot,
    input  logic [$clog2(MAX_ITEMS)-1:0]          i_gt,
    input  logic [dtc_pkg::DTC_TOTAL_W-1:0]       i_gain,
    output dtc_pkg::t_ctl                         o_ctl,
    output logic [VALUE_BITS-1:0]                 o_val,
    output logic [$clog2(MAX_ITEMS+1)-1:0]        o_slot,
    output logic [$clog2(MAX_ITEMS)-1:0]          o_gt,
    output logic [dtc_pkg::DTC_TOTAL_W-1:0]       o_gain
);
    import dtc_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int GW = $clog2(MAX_ITEMS);
    localparam int TW = DTC_TOTAL_W;

    // kept entry, valid only for items whose slot lies above this cell
    logic [VALUE_BITS-1:0] r_sv;
    logic [GW-1:0]         r_sg;

    // item pipeline register
    t_ctl                  r_ctl;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_slot;
    logic [GW-1:0]         r_gt;
    logic [TW-1:0]         r_gain;

    logic          w_hit;
    logic          w_store;
    logic [GW-1:0] n_gt;
    logic [TW-1:0] n_gain;
    logic [TW:0]   w_sum;

    // compare against the kept entry and accumulate
    always_comb begin
        w_hit   = i_ctl.valid && (CW'(INDEX) < i_slot) && (r_sv > i_val);
        w_store = i_ctl.valid && (i_slot == CW'(INDEX));
        w_sum   = {1'b0, i_gain} + {{(TW + 1 - GW){1'b0}}, r_sg};
        n_gt    = i_gt;
        n_gain  = i_gain;
        if (w_hit) begin
            n_gt   = i_gt + GW'(1);
            n_gain = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
        end
    end

    // item control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // item payload and kept entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val  <= i_val;
            r_slot <= i_slot;
            r_gt   <= n_gt;
            r_gain <= n_gain;
            if (w_store) begin
                r_sv <= i_val;
                r_sg <= i_gt;
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_val  = r_val;
    assign o_slot = r_slot;
    assign o_gt   = r_gt;
    assign o_gain = r_gain;

endmodule

FILE: src/dtc_acc.sv
// ----------------------------------------------------------------------------
// dtc_acc
// end of the chain: adds each item's gain into the running total and holds
// the result register
// ----------------------------------------------------------------------------
module dtc_acc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  dtc_pkg::t_ctl                   i_ctl,
    input  logic [dtc_pkg::DTC_TOTAL_W-1:0] i_gain,
    dtc_out_if.source                       o_out
);
    import dtc_pkg::*;

    localparam int TW = DTC_TOTAL_W;

    logic          r_seen;
    logic [TW-1:0] r_total;
    logic          r_ovalid;
    logic [TW-1:0] r_otot;
    logic          r_oovf;
    logic          r_ofin;

    logic [TW:0]   w_sum;
    logic [TW-1:0] n_total;
    logic          n_seen;

    // saturating add, skipped for dropped items
    always_comb begin
        w_sum   = {1'b0, r_total} + {1'b0, i_gain};
        n_total = r_total;
        if (!i_ctl.dropped) begin
            n_total = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
        end
        n_seen = r_seen | i_ctl.dropped;
    end

    // sequence state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (i_en) begin
            r_ovalid <= i_ctl.valid;
            if (i_ctl.valid) begin
                r_total <= i_ctl.last ? '0 : n_total;
                r_seen  <= i_ctl.last ? 1'b0 : n_seen;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_en && i_ctl.valid) begin
            r_otot <= n_total;
            r_oovf <= n_seen;
            r_ofin <= i_ctl.last;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.triple_total = r_otot;
    assign o_out.overflowed   = r_oovf;
    assign o_out.is_final     = r_ofin;

endmodule

FILE: src/decreasing_triple_counter_unit.sv
// ----------------------------------------------------------------------------
// decreasing_triple_counter_unit
// counts strictly decreasing triples of a value sequence in one pass
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one sequence element per item (value, last); o_out returns
//   one result per item (triple_total, overflowed, is_final), in order.
//   every item walks a row of MAX_ITEMS cells, one cell per cycle unless the
//   row is frozen; the cell that matches the item's slot keeps it, every
//   other kept cell with a greater value adds its count to the item.
//   an item passes the MAX_ITEMS cell registers and the result register
//   before o_out.valid. throughput: one item per cycle unless the row is
//   frozen, set by the one-cell-per-cycle shift; an item may enter each cycle.
//   items past MAX_ITEMS in one sequence are dropped and flag overflowed.
//   an item with last closes the sequence; the next item starts a new one.
//   reset clears the fill count, running total and all valid bits; kept
//   entries need no clearing.
//   when the receiver stalls with a result waiting, the whole row freezes
//   and i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "decreasing_triple_counter_unit_macros.svh"

module decreasing_triple_counter_unit #(
    parameter int MAX_ITEMS  = dtc_pkg::DTC_MAX_ITEMS,
    parameter int VALUE_BITS = dtc_pkg::DTC_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtc_in_if.sink     i_in,
    dtc_out_if.source  o_out
);
    import dtc_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int GW = $clog2(MAX_ITEMS);
    localparam int TW = DTC_TOTAL_W;
    localparam int IW = DTC_IN_VALUE_W;

    logic          w_en;
    logic          w_acc;
    logic          w_full;
    logic          w_stall;
    logic [CW-1:0] r_count;

    logic [VALUE_BITS-1:0] w_vin;

    // chain links, one more than cells
    t_ctl                  w_ctl  [0:MAX_ITEMS];
    logic [VALUE_BITS-1:0] w_val  [0:MAX_ITEMS];
    logic [CW-1:0]         w_slot [0:MAX_ITEMS];
    logic [GW-1:0]         w_gt   [0:MAX_ITEMS];
    logic [TW-1:0]         w_gain [0:MAX_ITEMS];

    // row advances whenever the result register can take a new entry
    assign w_en       = !o_out.valid || o_out.ready;
    assign w_stall    = o_out.valid && !o_out.ready;
    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid && w_en;
    assign w_full     = (r_count == CW'(MAX_ITEMS));

    // use the low value bits, zero-extended when VALUE_BITS is wider than the input
    generate
        if (VALUE_BITS <= IW) begin : g_vnarrow
            assign w_vin = i_in.value[VALUE_BITS-1:0];
        end else begin : g_vwide
            assign w_vin = {{(VALUE_BITS - IW){1'b0}}, i_in.value};
        end
    endgenerate

    // fill count of the current sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            if (i_in.last) begin
                r_count <= '0;
            end else if (!w_full) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // entry of the row
    assign w_ctl[0]  = '{valid: w_acc, last: i_in.last, dropped: w_full};
    assign w_val[0]  = w_vin;
    assign w_slot[0] = r_count;
    assign w_gt[0]   = '0;
    assign w_gain[0] = '0;

    // row of cells
    generate
        for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
            dtc_cell #(
                .INDEX      (c),
                .MAX_ITEMS  (MAX_ITEMS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_ctl[c]),
                .i_val   (w_val[c]),
                .i_slot  (w_slot[c]),
                .i_gt    (w_gt[c]),
                .i_gain  (w_gain[c]),
                .o_ctl   (w_ctl[c+1]),
                .o_val   (w_val[c+1]),
                .o_slot  (w_slot[c+1]),
                .o_gt    (w_gt[c+1]),
                .o_gain  (w_gain[c+1])
            );
        end
    endgenerate

    // running total and result register
    dtc_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[MAX_ITEMS]),
        .i_gain  (w_gain[MAX_ITEMS]),
        .o_out   (o_out)
    );

    // checks
    `DTC_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, w_stall, !i_in.ready, "input in stall")
    `DTC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ITEMS), "count too high")
    `DTC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_acc && i_in.last, r_count == '0, "count kept")

endmodule

FILE: tb/decreasing_triple_counter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decreasing_triple_counter_unit_tb
// self-checking regression of the decreasing triple counter: short directed
// sequences at the value extremes, equal values, one sequence that fills the
// store and overflows it, then random sequences under sender idling and
// receiver stalls; every result item is checked against a copy of the
// counter kept in the bench
// ----------------------------------------------------------------------------
module decreasing_triple_counter_unit_tb;
    import dtc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = DTC_MAX_ITEMS + 64;
    localparam int MAX_REPORTS  = 10;
    localparam int GREATER_W    = $clog2(DTC_MAX_ITEMS);
    localparam int FILL_W       = GREATER_W + 1;
    localparam int RANDOM_ITEMS_PER_PHASE = 225;
    localparam logic [DTC_TOTAL_W-1:0] TOTAL_SAT = '1;

    typedef logic [DTC_IN_VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [DTC_TOTAL_W-1:0] triple_total;
        logic                   overflowed;
        logic                   is_final;
    } t_triple_result;

    typedef enum int {
        STYLE_SPREAD,
        STYLE_FALLING,
        STYLE_RISING,
        STYLE_CLUSTER
    } t_seq_style;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtc_in_if  in_if ();
    dtc_out_if out_if ();

    decreasing_triple_counter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // idling mix of the current phase, in percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    int mismatch_count = 0;
    int unsigned cycle_count = 0;

    // bench copy of the counter state
    t_value               seq_values  [DTC_MAX_ITEMS];
    logic [GREATER_W-1:0] seq_greater [DTC_MAX_ITEMS];
    logic [FILL_W-1:0]    seq_fill    = '0;
    logic [DTC_TOTAL_W-1:0] seq_total = '0;
    logic                 seq_dropped = 1'b0;

    t_triple_result pending_results [$];

    // one element into the bench counter, returns the result it causes
    function automatic t_triple_result advance_triple_count(input t_value value,
                                                            input logic last);
        logic [63:0]          gain;
        logic [GREATER_W-1:0] greater;
        t_triple_result       res;
        if (seq_fill >= FILL_W'(DTC_MAX_ITEMS)) begin
            seq_dropped = 1'b1;
        end else begin
            gain    = 64'(seq_total);
            greater = '0;
            for (int i = 0; i < int'(seq_fill); i++) begin
                if (seq_values[i] > value) begin
                    gain    = gain + 64'(seq_greater[i]);
                    greater = greater + GREATER_W'(1);
                end
            end
            seq_values[seq_fill[GREATER_W-1:0]]  = value;
            seq_greater[seq_fill[GREATER_W-1:0]] = greater;
            seq_fill  = seq_fill + FILL_W'(1);
            seq_total = (gain > 64'(TOTAL_SAT)) ? TOTAL_SAT : gain[DTC_TOTAL_W-1:0];
        end
        res.triple_total = seq_total;
        res.overflowed   = seq_dropped;
        res.is_final     = last;
        // sequence closes after its last item
        if (last) begin
            seq_fill    = '0;
            seq_total   = '0;
            seq_dropped = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%s", msg);
        mismatch_count++;
    endtask

    // one item onto the input channel, with random idle cycles before it
    task automatic send_item(input t_value value, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            in_if.value <= $urandom;
            in_if.last  <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        in_if.last  <= last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_results = {pending_results, advance_triple_count(value, last)};
    endtask

    // whole sequence, last flag on its final element
    task automatic send_sequence(input t_value vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    // value extremes, single-item sequences, falling and rising runs
    task automatic test_directed_edges();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_sequence('{32'hFFFF_FFFF});
        send_sequence('{32'h0000_0000});
        send_sequence('{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0000_0001, 32'h0000_0000});
        send_sequence('{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                        32'hFFFF_FFFF, 32'h0000_0003});
    endtask

    // equal values count neither as greater nor as smaller
    task automatic test_equal_values();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_sequence('{32'd7, 32'd7, 32'd7, 32'd7});
        send_sequence('{32'd9, 32'd5, 32'd5, 32'd1});
        send_sequence('{32'd9, 32'd9, 32'd5, 32'd1});
        send_sequence('{32'd9, 32'd5, 32'd1, 32'd1});
    endtask

    // strictly falling run fills the store for the largest total, then
    // a few items past capacity are dropped and flagged
    task automatic test_store_full();
        t_value v;
        src_idle_pct  = 28;
        snk_stall_pct = 28;
        for (int n = 0; n < DTC_MAX_ITEMS + 6; n++) begin
            v = (n < DTC_MAX_ITEMS) ? 32'hFFFF_FFFF - 32'(n) * 32'd4 : t_value'($urandom);
            send_item(v, n == DTC_MAX_ITEMS + 5);
        end
    endtask

    // random sequences over the four idling phases
    task automatic test_random_sequences();
        int         src_mix [4] = '{0, 58, 0, 28};
        int         snk_mix [4] = '{0, 0, 58, 28};
        int         pick;
        int         seq_len;
        int         sent;
        t_seq_style style;
        bit [DTC_IN_VALUE_W-1:0] v;
        bit used_values [bit [DTC_IN_VALUE_W-1:0]];
        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct  = src_mix[phase];
            snk_stall_pct = snk_mix[phase];
            sent = 0;
            while (sent < RANDOM_ITEMS_PER_PHASE) begin
                // mostly distinct-value sequences, clustered duplicates as noise
                pick  = $urandom_range(0, 9);
                style = (pick == 0) ? STYLE_CLUSTER :
                        (pick < 4)  ? STYLE_FALLING :
                        (pick < 7)  ? STYLE_SPREAD  : STYLE_RISING;
                seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 40);
                used_values.delete();
                v = $urandom;
                for (int n = 0; n < seq_len; n++) begin
                    case (style)
                        STYLE_FALLING: begin
                            v = ($urandom_range(0, 4) != 0) ? v - $urandom_range(1, 4096)
                                                            : v + $urandom_range(1, 4096);
                        end
                        STYLE_RISING: begin
                            v = ($urandom_range(0, 4) != 0) ? v + $urandom_range(1, 4096)
                                                            : v - $urandom_range(1, 4096);
                        end
                        STYLE_CLUSTER: begin
                            v = $urandom_range(0, 7);
                        end
                        default: begin
                            v = $urandom;
                        end
                    endcase
                    if (style != STYLE_CLUSTER) begin
                        while (used_values.exists(v))
                            v = $urandom;
                    end
                    used_values[v] = 1'b1;
                    send_item(v, n == seq_len - 1);
                    sent++;
                end
            end
        end
    endtask

    // result side: check accepted items, then draw the next stall decision
    initial begin
        t_triple_result got;
        t_triple_result want;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.triple_total = out_if.triple_total;
                got.overflowed   = out_if.overflowed;
                got.is_final     = out_if.is_final;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: total %0d overflowed %b final %b",
                        got.triple_total, got.overflowed, got.is_final));
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.triple_total !== want.triple_total ||
                        got.overflowed !== want.overflowed ||
                        got.is_final !== want.is_final) begin
                        report_mismatch($sformatf(
                            "mismatch: expected total %0d ovf %b fin %b, got %0d ovf %b fin %b",
                            want.triple_total, want.overflowed, want.is_final,
                            got.triple_total, got.overflowed, got.is_final));
                    end
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // cycle limit on the whole run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("decreasing_triple_counter_unit regression: fail");
        $finish;
    end

    // reset, tests in turn, drain
    initial begin
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        in_if.last  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_equal_values();
        test_store_full();
        test_random_sequences();
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("decreasing_triple_counter_unit regression: pass");
        else
            $display("decreasing_triple_counter_unit regression: fail");
        $finish;
    end

endmodule
